// ----- hdl/sle_pkg.sv -----
// shared types and constants of the sequential list engine
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CMD_W       = 3;
    localparam int POS_W       = 9;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_PRIOR  = 3'd4,
        CMD_NEXT   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_INS_FLUSH,
        S_INS_WRITE,
        S_DEL_READ,
        S_DEL_TAKE,
        S_SHIFT_DOWN,
        S_DEL_FLUSH,
        S_GET_READ,
        S_GET_TAKE,
        S_SCAN,
        S_SCAN_LAST,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT_M1,
        IDX_POS_M1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_READ,
        MEM_SHIFT_UP,
        MEM_SHIFT_DOWN,
        MEM_SCAN,
        MEM_WRITE_VAL
    } mem_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_STATUS,
        RES_READ,
        RES_SCAN
    } res_op_t;

    typedef struct packed {
        logic    load;
        idx_op_t idx_op;
        mem_op_t mem_op;
        cnt_op_t cnt_op;
        res_op_t res_op;
        status_t res_status;
        logic    emit;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic bad_ins;
        logic bad_pos;
        logic full;
        logic append;
        logic empty;
        logic pos_is_count;
        logic idx_at_pos;
        logic idx_at_last;
        logic hit;
        logic out_busy;
    } sts_t;

endpackage

// ----- hdl/sequential_list_engine.sv -----
// top level of the sequential list engine
//
// an ordered list of signed words with a length count; one command word in,
// one result word out. the input stream (s_tvalid, s_tready, s_tdata) carries
// cmd, position and value; the output stream (m_tvalid, m_tready, m_tdata)
// carries status, out_value, found_position and list_length.
// one command is worked on at a time; s_tready is high only while idle.
// the result word rises together with s_tready. the time from one accepted
// command to the next does not depend on the list length for get, append,
// delete of the last entry, a bad position, a full list, a search of an empty
// list or an unused code; an insert at p <= n shifts the entries from p up,
// a delete at p < n shifts the entries after p down, and locate, prior and
// next scan from the first entry with an early exit on the first match (n is
// the list length before the command). the time is set by the single read
// port of the entry store: a shift or a search touches one entry per cycle.
// reset empties the list at once; the store itself is not cleared.
// a result waits in the output register while m_tready is low; the next
// command is still taken, and its result is held back until the register
// is free.
`timescale 1ns / 1ps

module sequential_list_engine #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cmd[2:0], position[11:3], value[43:12], zero pad
    input  logic [sle_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], out_value[33:2], found_position[42:34], list_length[51:43], zero pad
    output logic [sle_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import sle_pkg::*;

    localparam int OUT_USED = STATUS_W + DATA_W + 2 * POS_W;

    ctl_t                     ctl;
    sts_t                     sts;
    logic [CMD_W-1:0]         in_cmd;
    logic [POS_W-1:0]         in_position;
    logic signed [DATA_W-1:0] in_value;
    logic [STATUS_W-1:0]      out_status;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         out_found_position;
    logic [POS_W-1:0]         out_list_length;

    assign in_cmd      = s_tdata[CMD_W-1:0];
    assign in_position = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign in_value    = signed'(s_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W]);

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    sle_datapath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .in_cmd             (in_cmd),
        .in_position        (in_position),
        .in_value           (in_value),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (out_status),
        .out_value          (out_value),
        .out_found_position (out_found_position),
        .out_list_length    (out_list_length)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_USED){1'b0}}, out_list_length,
                      out_found_position, out_value, out_status};

endmodule

// ----- hdl/sle_ctrl.sv -----
// command sequencer of the sequential list engine
`timescale 1ns / 1ps

module sle_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sle_pkg::sts_t  sts,
    output sle_pkg::ctl_t  ctl
);
    import sle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.bad_ins || sts.full)
                        begin
                            state_next = S_EMIT;
                        end
                        else if (sts.append)
                        begin
                            state_next = S_INS_WRITE;
                        end
                        else
                        begin
                            state_next = S_SHIFT_UP;
                        end
                    end
                    CMD_DELETE:
                    begin
                        state_next = sts.bad_pos ? S_EMIT : S_DEL_READ;
                    end
                    CMD_GET:
                    begin
                        state_next = sts.bad_pos ? S_EMIT : S_GET_READ;
                    end
                    CMD_LOCATE, CMD_PRIOR, CMD_NEXT:
                    begin
                        state_next = sts.empty ? S_EMIT : S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                if (sts.idx_at_pos)
                begin
                    state_next = S_INS_FLUSH;
                end
            end
            S_INS_FLUSH:  state_next = S_INS_WRITE;
            S_INS_WRITE:  state_next = S_EMIT;
            S_DEL_READ:   state_next = S_DEL_TAKE;
            S_DEL_TAKE:
            begin
                state_next = sts.pos_is_count ? S_EMIT : S_SHIFT_DOWN;
            end
            S_SHIFT_DOWN:
            begin
                if (sts.idx_at_last)
                begin
                    state_next = S_DEL_FLUSH;
                end
            end
            S_DEL_FLUSH:  state_next = S_EMIT;
            S_GET_READ:   state_next = S_GET_TAKE;
            S_GET_TAKE:   state_next = S_EMIT;
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.idx_at_last)
                begin
                    state_next = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        ctl.load       = 1'b0;
        ctl.idx_op     = IDX_HOLD;
        ctl.mem_op     = MEM_NONE;
        ctl.cnt_op     = CNT_HOLD;
        ctl.res_op     = RES_NONE;
        ctl.res_status = ST_OK;
        ctl.emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_DECODE:
            begin
                case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.bad_ins)
                        begin
                            ctl.res_op     = RES_STATUS;
                            ctl.res_status = ST_BAD_POS;
                        end
                        else if (sts.full)
                        begin
                            ctl.res_op     = RES_STATUS;
                            ctl.res_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.idx_op = IDX_COUNT_M1;
                        end
                    end
                    CMD_DELETE, CMD_GET:
                    begin
                        if (sts.bad_pos)
                        begin
                            ctl.res_op     = RES_STATUS;
                            ctl.res_status = ST_BAD_POS;
                        end
                        else
                        begin
                            ctl.idx_op = IDX_POS_M1;
                        end
                    end
                    CMD_LOCATE, CMD_PRIOR, CMD_NEXT:
                    begin
                        if (sts.empty)
                        begin
                            ctl.res_op     = RES_STATUS;
                            ctl.res_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            ctl.idx_op = IDX_ZERO;
                        end
                    end
                    default:
                    begin
                        ctl.res_op     = RES_STATUS;
                        ctl.res_status = ST_OK;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                ctl.mem_op = MEM_SHIFT_UP;
                ctl.idx_op = IDX_DEC;
            end
            S_INS_FLUSH:
            begin
                ctl.mem_op = MEM_NONE;
            end
            S_INS_WRITE:
            begin
                ctl.mem_op     = MEM_WRITE_VAL;
                ctl.cnt_op     = CNT_INC;
                ctl.res_op     = RES_STATUS;
                ctl.res_status = ST_OK;
            end
            S_DEL_READ:
            begin
                ctl.mem_op = MEM_READ;
                ctl.idx_op = IDX_INC;
            end
            S_DEL_TAKE:
            begin
                ctl.res_op = RES_READ;
                if (sts.pos_is_count)
                begin
                    ctl.cnt_op = CNT_DEC;
                end
            end
            S_SHIFT_DOWN:
            begin
                ctl.mem_op = MEM_SHIFT_DOWN;
                ctl.idx_op = IDX_INC;
            end
            S_DEL_FLUSH:
            begin
                ctl.cnt_op = CNT_DEC;
            end
            S_GET_READ:
            begin
                ctl.mem_op = MEM_READ;
            end
            S_GET_TAKE:
            begin
                ctl.res_op = RES_READ;
            end
            S_SCAN:
            begin
                ctl.mem_op = MEM_SCAN;
                ctl.idx_op = IDX_INC;
                if (sts.hit)
                begin
                    ctl.res_op = RES_SCAN;
                end
            end
            S_SCAN_LAST:
            begin
                ctl.res_op = RES_SCAN;
            end
            S_EMIT:
            begin
                ctl.emit = !sts.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/sle_datapath.sv -----
// entry store, length count, scan compare and result register of the list engine
`timescale 1ns / 1ps

module sle_datapath #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sle_pkg::ctl_t                        ctl,
    output sle_pkg::sts_t                        sts,
    input  logic [sle_pkg::CMD_W-1:0]            in_cmd,
    input  logic [sle_pkg::POS_W-1:0]            in_position,
    input  logic signed [sle_pkg::DATA_W-1:0]    in_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sle_pkg::STATUS_W-1:0]         out_status,
    output logic signed [sle_pkg::DATA_W-1:0]    out_value,
    output logic [sle_pkg::POS_W-1:0]            out_found_position,
    output logic [sle_pkg::POS_W-1:0]            out_list_length
);
    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

    logic [CMD_W-1:0]         cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;
    logic [ELEMENT_WIDTH-1:0] prev_reg;
    logic                     wr_pend_reg, wr_pend_next;
    logic [AW-1:0]            wr_addr_reg, wr_addr_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]            cmp_idx_reg, cmp_idx_next;
    status_t                  res_status_reg, res_status_next;
    logic [DATA_W-1:0]        res_value_reg, res_value_next;
    logic [POS_W-1:0]         res_found_reg, res_found_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic [POS_W-1:0]         out_found_reg;
    logic [POS_W-1:0]         out_length_reg;

    logic [XW-1:0]            pos_x, cnt_x, idx_x;
    logic [CW-1:0]            pos_m1, idx_inc, idx_dec;
    logic                     rd_en;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;
    logic                     eq_cur, eq_prev, idx_nz, hit;
    cmd_t                     cmd;

    assign pos_x   = XW'(pos_reg);
    assign cnt_x   = XW'(count_reg);
    assign idx_x   = XW'(idx_reg);
    assign pos_m1  = CW'(pos_x - XW'(1));
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign cmd     = cmd_t'(cmd_reg);

    // scan compare on the word read last cycle and the one before it
    assign eq_cur  = (rd_data_reg == val_reg);
    assign eq_prev = (prev_reg == val_reg);
    assign idx_nz  = (cmp_idx_reg != '0);

    always_comb
    begin
        case (cmd)
            CMD_LOCATE: hit = eq_cur;
            CMD_PRIOR:  hit = idx_nz && eq_cur;
            CMD_NEXT:   hit = idx_nz && eq_prev;
            default:    hit = 1'b0;
        endcase
        hit = hit && cmp_valid_reg;
    end

    always_comb
    begin
        sts.cmd          = cmd;
        sts.bad_ins      = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
        sts.bad_pos      = (pos_x == '0) || (pos_x > cnt_x);
        sts.full         = (cnt_x >= XW'(CAPACITY));
        sts.append       = (pos_x == cnt_x + XW'(1));
        sts.empty        = (count_reg == '0);
        sts.pos_is_count = (pos_x == cnt_x);
        sts.idx_at_pos   = (idx_x == pos_x - XW'(1));
        sts.idx_at_last  = (idx_x == cnt_x - XW'(1));
        sts.hit          = hit;
        sts.out_busy     = out_valid_reg && !out_ready;
    end

    // memory port control
    assign rd_en = (ctl.mem_op == MEM_READ) || (ctl.mem_op == MEM_SHIFT_UP) ||
                   (ctl.mem_op == MEM_SHIFT_DOWN) || (ctl.mem_op == MEM_SCAN);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = rd_data_reg;
        if (wr_pend_reg)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.mem_op == MEM_WRITE_VAL)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_m1[AW-1:0];
            wr_data = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        case (ctl.idx_op)
            IDX_COUNT_M1: idx_next = CW'(cnt_x - XW'(1));
            IDX_POS_M1:   idx_next = pos_m1;
            IDX_ZERO:     idx_next = '0;
            IDX_INC:      idx_next = idx_inc;
            IDX_DEC:      idx_next = idx_dec;
            default:      idx_next = idx_reg;
        endcase
    end

    // a shifted word is written back in the cycle after its read
    always_comb
    begin
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        case (ctl.mem_op)
            MEM_SHIFT_UP:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = idx_inc[AW-1:0];
            end
            MEM_SHIFT_DOWN:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = idx_dec[AW-1:0];
            end
            default:
            begin
                wr_pend_next = 1'b0;
            end
        endcase
    end

    assign cmp_valid_next = (ctl.mem_op == MEM_SCAN);
    assign cmp_idx_next   = (ctl.mem_op == MEM_SCAN) ? idx_reg : cmp_idx_reg;

    always_comb
    begin
        case (ctl.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_comb
    begin
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        case (ctl.res_op)
            RES_STATUS:
            begin
                res_status_next = ctl.res_status;
                res_value_next  = '0;
                res_found_next  = '0;
            end
            RES_READ:
            begin
                res_status_next = ST_OK;
                res_value_next  = DATA_W'(signed'(rd_data_reg));
                res_found_next  = '0;
            end
            RES_SCAN:
            begin
                res_status_next = hit ? ST_OK : ST_NOT_FOUND;
                res_value_next  = '0;
                res_found_next  = '0;
                if (hit)
                begin
                    case (cmd)
                        CMD_LOCATE: res_found_next = POS_W'(cmp_idx_reg) + POS_W'(1);
                        CMD_PRIOR:  res_value_next = DATA_W'(signed'(prev_reg));
                        CMD_NEXT:   res_value_next = DATA_W'(signed'(rd_data_reg));
                        default:    res_value_next = '0;
                    endcase
                end
            end
            default:
            begin
                res_status_next = res_status_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_cmd;
            pos_reg <= in_position;
            val_reg <= ELEMENT_WIDTH'(in_value);
        end
        idx_reg        <= idx_next;
        wr_addr_reg    <= wr_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        if (cmp_valid_reg)
        begin
            prev_reg <= rd_data_reg;
        end
        if (ctl.emit)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_found_reg  <= res_found_reg;
            out_length_reg <= POS_W'(count_reg);
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_value          = signed'(out_value_reg);
    assign out_found_position = out_found_reg;
    assign out_list_length    = out_length_reg;

endmodule
